// ----- rtl/mwpg_pkg.sv -----
package mwpg_pkg;

    // Default geometry of the generator.
    localparam int CHANNELS_DEF  = 8;
    localparam int SLOTS_DEF     = 256;
    localparam int FRAC_BITS_DEF = 15;

    // Fixed field widths of the request and result channels.
    localparam int CH_W    = 3;
    localparam int VAL_W   = 18;
    localparam int LIMIT_W = 17;
    localparam int PINS_W  = 8;

    // One channel's complete parameter set, also the active waveform state.
    typedef struct packed {
        logic signed [VAL_W-1:0] offset;
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
        logic signed [VAL_W-1:0] c;
        logic signed [VAL_W-1:0] s;
        logic signed [VAL_W-1:0] step;
        logic [LIMIT_W-1:0]      limit;
    } t_chan_set;

    // Controls that the sequencer sends to every cell of the ring.
    typedef struct packed {
        logic            load;
        logic [CH_W-1:0] channel;
        logic            apply;
        logic            shift;
    } t_cell_ctl;

endpackage

// ----- rtl/mwpg_if.sv -----
interface mwpg_in_if import mwpg_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic [CH_W-1:0]         channel;
    logic signed [VAL_W-1:0] offset;
    logic signed [VAL_W-1:0] start_x;
    logic signed [VAL_W-1:0] start_y;
    logic signed [VAL_W-1:0] cos_term;
    logic signed [VAL_W-1:0] sin_term;
    logic signed [VAL_W-1:0] tri_step;
    logic [LIMIT_W-1:0]      tri_limit;

    modport source (
        output valid, command, channel, offset, start_x, start_y,
               cos_term, sin_term, tri_step, tri_limit,
        input  ready
    );
    modport sink (
        input  valid, command, channel, offset, start_x, start_y,
               cos_term, sin_term, tri_step, tri_limit,
        output ready
    );
endinterface

interface mwpg_out_if import mwpg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [PINS_W-1:0] pins;
    logic              frame_end;

    modport source (output valid, pins, frame_end, input ready);
    modport sink (input valid, pins, frame_end, output ready);
endinterface

// ----- rtl/mwpg_cell.sv -----
module mwpg_cell import mwpg_pkg::*; #(
    parameter int INDEX = 0,
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cell_ctl                    i_ctl,
    input  t_chan_set                    i_load_set,
    input  t_chan_set                    i_shift_set,
    input  logic [$clog2(SLOTS+1)-1:0]   i_shift_duty,
    input  logic [$clog2(SLOTS)-1:0]     i_slot,
    output t_chan_set                    o_set,
    output logic [$clog2(SLOTS+1)-1:0]   o_duty,
    output logic                         o_pin
);

    localparam int DUTY_W = $clog2(SLOTS+1);
    localparam bit LOADABLE = INDEX < (1 << CH_W);
    localparam logic [CH_W-1:0] MY_CH = CH_W'(INDEX);

    t_chan_set         r_active;
    t_chan_set         r_staged;
    logic              r_staged_vld;
    logic [DUTY_W-1:0] r_duty;
    logic              w_hit;

    // Only the first eight positions can be addressed by a load.
    assign w_hit = LOADABLE && i_ctl.load && (i_ctl.channel == MY_CH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= '0;
            r_staged     <= '0;
            r_staged_vld <= 1'b0;
            r_duty       <= '0;
        end else begin
            if (w_hit) begin
                r_staged     <= i_load_set;
                r_staged_vld <= 1'b1;
            end
            if (i_ctl.apply) begin
                if (r_staged_vld) begin
                    r_active <= r_staged;
                end
                r_staged_vld <= 1'b0;
            end
            if (i_ctl.shift) begin
                r_active <= i_shift_set;
                r_duty   <= i_shift_duty;
            end
        end
    end

    assign o_set  = r_active;
    assign o_duty = r_duty;
    assign o_pin  = DUTY_W'(i_slot) < r_duty;

endmodule

// ----- rtl/mwpg_update.sv -----
module mwpg_update import mwpg_pkg::*; #(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_run,
    input  t_chan_set                   i_head,
    output logic                        o_done,
    output t_chan_set                   o_set,
    output logic [$clog2(SLOTS+1)-1:0]  o_duty
);

    localparam int DUTY_W = $clog2(SLOTS+1);
    localparam int A_W    = VAL_W + 1;
    localparam int PROD_W = A_W + VAL_W;
    localparam int ACC_W  = PROD_W + 2;
    localparam int TRI_W  = VAL_W + 2;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'((1 << (VAL_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] ACC_MIN = -(ACC_W'(1) <<< (VAL_W - 1));
    localparam logic signed [ACC_W-1:0] ACC_SLOTS = ACC_W'(SLOTS);
    localparam logic signed [VAL_W-1:0] SLOTS_V = VAL_W'(SLOTS);
    localparam logic signed [TRI_W-1:0] TRI_MAX = TRI_W'((1 << (VAL_W - 1)) - 1);
    localparam logic signed [TRI_W-1:0] TRI_MIN = -(TRI_W'(1) <<< (VAL_W - 1));
    localparam logic signed [VAL_W-1:0] VAL_MAX = VAL_W'((1 << (VAL_W - 1)) - 1);
    localparam logic signed [VAL_W-1:0] VAL_MIN = -(VAL_W'(1) <<< (VAL_W - 1));

    // Six steps per channel around the one multiplier.
    typedef enum logic [5:0] {
        ST_YC   = 6'b000001,
        ST_XS   = 6'b000010,
        ST_XC   = 6'b000100,
        ST_YS   = 6'b001000,
        ST_VAL  = 6'b010000,
        ST_DONE = 6'b100000
    } t_step;

    t_step                    r_step;
    t_step                    n_step;
    logic signed [A_W-1:0]    w_a;
    logic signed [VAL_W-1:0]  w_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [VAL_W-1:0]  r_ynew;
    logic signed [VAL_W-1:0]  r_xnew;
    logic signed [ACC_W-1:0]  w_prod_x;
    logic signed [ACC_W-1:0]  w_dq;
    logic signed [TRI_W-1:0]  w_ty;
    logic signed [TRI_W-1:0]  w_lim;
    logic signed [TRI_W-1:0]  w_ny;
    logic                     w_flip;
    logic signed [VAL_W-1:0]  w_neg_step;

    function automatic logic signed [VAL_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] q;
        q = v >>> FRAC_BITS;
        if (q > ACC_MAX) begin
            return VAL_MAX;
        end else if (q < ACC_MIN) begin
            return VAL_MIN;
        end
        return q[VAL_W-1:0];
    endfunction

    always_comb begin
        unique case (r_step)
            ST_YC:   n_step = ST_XS;
            ST_XS:   n_step = ST_XC;
            ST_XC:   n_step = ST_YS;
            ST_YS:   n_step = ST_VAL;
            ST_VAL:  n_step = ST_DONE;
            ST_DONE: n_step = ST_YC;
            default: n_step = ST_YC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || !i_run) begin
            r_step <= ST_YC;
        end else begin
            r_step <= n_step;
        end
    end

    // Operand selection for the step now under way.
    always_comb begin
        unique case (r_step)
            ST_YC: begin
                w_a = A_W'(i_head.y);
                w_b = i_head.c;
            end
            ST_XS: begin
                w_a = A_W'(i_head.x);
                w_b = i_head.s;
            end
            ST_XC: begin
                w_a = A_W'(i_head.x);
                w_b = i_head.c;
            end
            ST_YS: begin
                w_a = A_W'(i_head.y);
                w_b = i_head.s;
            end
            ST_VAL: begin
                w_a = A_W'(i_head.offset) + A_W'(i_head.y);
                w_b = SLOTS_V;
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod_x = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod <= w_a * w_b;
        unique case (r_step)
            ST_XS:   r_acc  <= w_prod_x + HALF;
            ST_XC:   r_ynew <= round_sat(r_acc + w_prod_x);
            ST_YS:   r_acc  <= w_prod_x + HALF;
            ST_VAL:  r_xnew <= round_sat(r_acc - w_prod_x);
            default: ;
        endcase
    end

    // Duty count from the scaled value, clamped to the frame length.
    always_comb begin
        w_dq = (w_prod_x + HALF) >>> FRAC_BITS;
        if (w_dq < 0) begin
            o_duty = '0;
        end else if (w_dq > ACC_SLOTS) begin
            o_duty = DUTY_W'(SLOTS);
        end else begin
            o_duty = w_dq[DUTY_W-1:0];
        end
    end

    // Triangle ramp that reflects at the amplitude.
    always_comb begin
        w_ty       = TRI_W'(i_head.y) + TRI_W'(i_head.step);
        w_lim      = TRI_W'({1'b0, i_head.limit});
        w_flip     = 1'b0;
        w_ny       = w_ty;
        w_neg_step = (i_head.step == VAL_MIN) ? VAL_MAX : -i_head.step;
        if (w_ty > w_lim) begin
            w_ny   = (w_lim <<< 1) - w_ty;
            w_flip = 1'b1;
        end else if (w_ty < -w_lim) begin
            w_ny   = -(w_lim <<< 1) - w_ty;
            w_flip = 1'b1;
        end
    end

    always_comb begin
        o_set = i_head;
        if (i_head.step == '0) begin
            o_set.y = r_ynew;
            o_set.x = r_xnew;
        end else begin
            if (w_ny > TRI_MAX) begin
                o_set.y = VAL_MAX;
            end else if (w_ny < TRI_MIN) begin
                o_set.y = VAL_MIN;
            end else begin
                o_set.y = w_ny[VAL_W-1:0];
            end
            if (w_flip) begin
                o_set.step = w_neg_step;
            end
        end
    end

    assign o_done = (r_step == ST_DONE);

endmodule

// ----- rtl/multichannel_wave_pwm_generator_top.sv -----
// Channel   Direction  Requests carried
// i_in      sink       load (one channel's parameter set) or tick (one PWM slot)
// o_out     source     pin levels and end-of-frame flag, one per tick
//
// A load, and a tick that is not the first slot of a frame, need no sequencer pass;
// the tick's result is in the output register in the next cycle.
// The first slot of a frame runs the sequencer through apply, ring update and emit:
// each channel passes in turn through the one shared multiplier, six steps apiece.
// Synchronous active-low reset clears every channel, staged set and the slot index.
// Input is taken when the block is idle and the output register is free or being read.
module multichannel_wave_pwm_generator_top import mwpg_pkg::*; #(
    parameter int CHANNELS  = CHANNELS_DEF,
    parameter int SLOTS     = SLOTS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mwpg_in_if.sink     i_in,
    mwpg_out_if.source  o_out
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int DUTY_W = $clog2(SLOTS+1);
    localparam int CNT_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [CNT_W-1:0]  LAST_CH   = CNT_W'(CHANNELS - 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // Sequencer: idle, copy staged sets, walk the ring, show slot zero.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_APPLY  = 4'b0010,
        S_UPDATE = 4'b0100,
        S_EMIT   = 4'b1000
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_ch_cnt;
    logic [SLOT_W-1:0]  r_slot;
    logic [SLOT_W-1:0]  w_slot_next;
    logic               r_out_valid;
    logic [PINS_W-1:0]  r_out_pins;
    logic               r_out_frame_end;
    logic               w_accept;
    logic               w_tick;
    logic               w_done;
    logic [PINS_W-1:0]  w_pins;
    t_cell_ctl          w_ctl;
    t_chan_set          w_load_set;
    t_chan_set          w_upd_set;
    logic [DUTY_W-1:0]  w_upd_duty;
    t_chan_set          w_set  [CHANNELS];
    logic [DUTY_W-1:0]  w_duty [CHANNELS];
    logic [CHANNELS-1:0] w_pin;

    assign i_in.ready = (r_state == S_IDLE) && (!r_out_valid || o_out.ready);
    assign w_accept   = i_in.valid && i_in.ready;
    assign w_tick     = w_accept && !i_in.command;

    assign w_load_set.offset = i_in.offset;
    assign w_load_set.x      = i_in.start_x;
    assign w_load_set.y      = i_in.start_y;
    assign w_load_set.c      = i_in.cos_term;
    assign w_load_set.s      = i_in.sin_term;
    assign w_load_set.step   = i_in.tri_step;
    assign w_load_set.limit  = i_in.tri_limit;

    assign w_ctl.load    = w_accept && i_in.command;
    assign w_ctl.channel = i_in.channel;
    assign w_ctl.apply   = (r_state == S_APPLY);
    assign w_ctl.shift   = (r_state == S_UPDATE) && w_done;

    // The ring of channel cells: the head feeds the update unit, whose result
    // enters at the tail, so after one lap every channel is back in place.
    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        if (i == CHANNELS - 1) begin : g_tail
            mwpg_cell #(.INDEX(i), .SLOTS(SLOTS)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_load_set   (w_load_set),
                .i_shift_set  (w_upd_set),
                .i_shift_duty (w_upd_duty),
                .i_slot       (r_slot),
                .o_set        (w_set[i]),
                .o_duty       (w_duty[i]),
                .o_pin        (w_pin[i])
            );
        end else begin : g_body
            mwpg_cell #(.INDEX(i), .SLOTS(SLOTS)) u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_load_set   (w_load_set),
                .i_shift_set  (w_set[i+1]),
                .i_shift_duty (w_duty[i+1]),
                .i_slot       (r_slot),
                .o_set        (w_set[i]),
                .o_duty       (w_duty[i]),
                .o_pin        (w_pin[i])
            );
        end
    end

    mwpg_update #(.SLOTS(SLOTS), .FRAC_BITS(FRAC_BITS)) u_update (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (r_state == S_UPDATE),
        .i_head  (w_set[0]),
        .o_done  (w_done),
        .o_set   (w_upd_set),
        .o_duty  (w_upd_duty)
    );

    // Only the first eight channels reach the pin word.
    for (genvar j = 0; j < PINS_W; j++) begin : g_pins
        if (j < CHANNELS) begin : g_used
            assign w_pins[j] = w_pin[j];
        end else begin : g_none
            assign w_pins[j] = 1'b0;
        end
    end

    assign w_slot_next = (r_slot == LAST_SLOT) ? '0 : r_slot + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch_cnt    <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_tick) begin
                        if (r_slot == '0) begin
                            r_state <= S_APPLY;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_slot      <= w_slot_next;
                        end
                    end
                end
                S_APPLY: begin
                    r_ch_cnt <= '0;
                    r_state  <= S_UPDATE;
                end
                S_UPDATE: begin
                    if (w_done) begin
                        r_ch_cnt <= r_ch_cnt + 1'b1;
                        if (r_ch_cnt == LAST_CH) begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_slot      <= w_slot_next;
                    r_state     <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The result payload is captured whenever a slot is shown.
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) || (w_tick && (r_slot != '0))) begin
            r_out_pins      <= w_pins;
            r_out_frame_end <= (r_slot == LAST_SLOT);
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.pins      = r_out_pins;
    assign o_out.frame_end = r_out_frame_end;

    // The output register must be empty when slot zero is shown.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_out_valid)
        else $error("slot zero would overwrite a pending result");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |=> r_out_valid)
        else $error("slot zero result not presented");

    a_lap_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPDATE) && w_done && (r_ch_cnt == LAST_CH)) |=> (r_state == S_EMIT))
        else $error("ring lap did not end after the last channel");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && w_tick && (r_slot == '0)) |=> (r_state == S_APPLY))
        else $error("first slot of a frame skipped the channel update");

endmodule
